### rtl/lpht_pkg.sv
// lpht_pkg: shared types, codes and sizes for the linear probing hash table
// used by every module under rtl/, no dependencies of its own
package lpht_pkg;

  localparam int KEY_W       = 64;
  localparam int OFF_W       = 64;
  localparam int CMD_W       = 2;
  localparam int STATUS_W    = 2;
  localparam int IN_DATA_W   = KEY_W + OFF_W;
  localparam int IN_USER_W   = CMD_W;
  localparam int OUT_DATA_W  = OFF_W;
  localparam int OUT_USER_W  = 1 + STATUS_W;

  // configuration port
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_IDX_W   = 1;
  localparam int CAP_CFG_W   = 11;
  localparam logic [CAP_CFG_W-1:0] CAP_RESET = 11'd16;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'b0;

  localparam int MIN_CAPACITY        = 16;
  localparam int DEFAULT_TABLE_DEPTH = 1024;

  // remainder unit retires this many dividend bits per cycle
  localparam int RADIX_BITS  = 4;
  localparam int DIV_STEPS   = KEY_W / RADIX_BITS;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_FULL      = 2'd2,
    STATUS_ZERO      = 2'd3
  } status_e_t;

  // controller to datapath
  typedef struct packed {
    logic      accept;
    logic      div_start;
    logic      probe_init;
    logic      probe_advance;
    logic      ins_write;
    logic      clr_start;
    logic      clr_write;
    logic      load_result;
    logic      res_found;
    status_e_t res_status;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    cmd_e_t in_cmd;
    logic   in_hash_zero;
    logic   op_insert;
    logic   div_busy;
    logic   slot_empty;
    logic   slot_match;
    logic   probe_last;
    logic   clr_last;
    logic   out_free;
  } sts_t;

endpackage

### rtl/lpht_rem.sv
// lpht_rem: iterative 64-bit remainder by the live capacity, RADIX_BITS per cycle
// depends on lpht_pkg
module lpht_rem #(
  parameter int TABLE_DEPTH = lpht_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    start,
  input  logic [lpht_pkg::KEY_W-1:0]              dividend,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0]        divisor,
  output logic                                    busy,
  output logic [$clog2(TABLE_DEPTH)-1:0]          rem
);
  import lpht_pkg::*;

  localparam int CAP_W  = $clog2(TABLE_DEPTH + 1);
  localparam int ADDR_W = $clog2(TABLE_DEPTH);

  logic [KEY_W-1:0]     dvd;
  logic [KEY_W-1:0]     dvd_next;
  logic [CAP_W:0]       acc;
  logic [CAP_W:0]       acc_next;
  logic [CAP_W-1:0]     dvs;
  logic [DIV_CNT_W-1:0] cnt;

  // restoring steps, remainder stays below the divisor between steps
  always_comb begin
    acc_next = acc;
    dvd_next = dvd;
    for (int k = 0; k < RADIX_BITS; k++) begin
      acc_next = {acc_next[CAP_W-1:0], dvd_next[KEY_W-1]};
      dvd_next = {dvd_next[KEY_W-2:0], 1'b0};
      if (acc_next >= {1'b0, dvs}) begin
        acc_next = acc_next - {1'b0, dvs};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= DIV_CNT_W'(DIV_STEPS);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dvs <= divisor;
      acc <= '0;
    end else if (busy) begin
      dvd <= dvd_next;
      acc <= acc_next;
    end
  end

  assign busy = (cnt != '0);
  assign rem  = acc[ADDR_W-1:0];

endmodule

### rtl/lpht_datapath.sv
// lpht_datapath: slot memories, probe pointer, clear sweep and result register
// depends on lpht_pkg and lpht_rem
module lpht_datapath #(
  parameter int TABLE_DEPTH = lpht_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  lpht_pkg::ctl_t                    ctl,
  output lpht_pkg::sts_t                    sts,
  input  logic [lpht_pkg::CAP_CFG_W-1:0]    capacity,
  input  logic [lpht_pkg::IN_DATA_W-1:0]    in_data,
  input  logic [lpht_pkg::IN_USER_W-1:0]    in_user,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [lpht_pkg::OUT_DATA_W-1:0]   out_data,
  output logic [lpht_pkg::OUT_USER_W-1:0]   out_user
);
  import lpht_pkg::*;

  localparam int CAP_W  = $clog2(TABLE_DEPTH + 1);
  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int SAT_W  = (CAP_W > CAP_CFG_W) ? CAP_W : CAP_CFG_W;

  logic [KEY_W-1:0] slot_hash   [TABLE_DEPTH];
  logic [OFF_W-1:0] slot_offset [TABLE_DEPTH];

  logic [KEY_W-1:0]  in_hash;
  logic [OFF_W-1:0]  in_off;
  cmd_e_t            op;
  logic [KEY_W-1:0]  hash_r;
  logic [OFF_W-1:0]  off_r;
  logic [CAP_W-1:0]  cap_live;
  logic [CAP_W-1:0]  cap_sat;
  logic [SAT_W-1:0]  cap_ext;
  logic              div_busy;
  logic [ADDR_W-1:0] div_rem;
  logic [ADDR_W-1:0] pos;
  logic [CAP_W-1:0]  pos_inc;
  logic [CAP_W-1:0]  n;
  logic [ADDR_W-1:0] clr_ptr;
  logic [KEY_W-1:0]  hash_q;
  logic [OFF_W-1:0]  off_q;
  logic              hash_we;
  logic [ADDR_W-1:0] hash_wa;
  logic [KEY_W-1:0]  hash_wd;
  logic              res_found;
  status_e_t         res_status;
  logic [OFF_W-1:0]  res_offset;

  assign in_hash = in_data[KEY_W-1:0];
  assign in_off  = in_data[IN_DATA_W-1:KEY_W];

  // capacity register clamped to the usable range
  always_comb begin
    cap_ext = SAT_W'(capacity);
    if (cap_ext < SAT_W'(MIN_CAPACITY)) begin
      cap_sat = CAP_W'(MIN_CAPACITY);
    end else if (cap_ext > SAT_W'(TABLE_DEPTH)) begin
      cap_sat = CAP_W'(TABLE_DEPTH);
    end else begin
      cap_sat = cap_ext[CAP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      op       <= cmd_e_t'(in_user);
      hash_r   <= in_hash;
      off_r    <= in_off;
      cap_live <= cap_sat;
    end
  end

  lpht_rem #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.div_start),
    .dividend (in_hash),
    .divisor  (cap_sat),
    .busy     (div_busy),
    .rem      (div_rem)
  );

  // probe pointer wraps at the live capacity
  assign pos_inc = CAP_W'(pos) + CAP_W'(1);

  always_ff @(posedge clk) begin
    if (ctl.probe_init) begin
      pos <= div_rem;
      n   <= '0;
    end else if (ctl.probe_advance) begin
      pos <= (pos_inc == cap_live) ? '0 : pos_inc[ADDR_W-1:0];
      n   <= n + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clr_start) begin
      clr_ptr <= '0;
    end else if (ctl.clr_write) begin
      clr_ptr <= clr_ptr + 1'b1;
    end
  end

  // single write port shared by the clear sweep and inserts
  assign hash_we = ctl.clr_write | ctl.ins_write;
  assign hash_wa = ctl.clr_write ? clr_ptr : pos;
  assign hash_wd = ctl.clr_write ? '0 : hash_r;

  always_ff @(posedge clk) begin
    if (hash_we) begin
      slot_hash[hash_wa] <= hash_wd;
    end
    hash_q <= slot_hash[pos];
  end

  always_ff @(posedge clk) begin
    if (ctl.ins_write) begin
      slot_offset[pos] <= off_r;
    end
    off_q <= slot_offset[pos];
  end

  // result register, takes a new result as the old one leaves
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign res_offset = ctl.res_found ? off_q : '0;

  always_ff @(posedge clk) begin
    if (ctl.load_result) begin
      res_found  <= ctl.res_found;
      res_status <= ctl.res_status;
      out_data   <= res_offset;
    end
  end

  assign out_user = {res_status, res_found};

  always_comb begin
    sts.in_cmd       = cmd_e_t'(in_user);
    sts.in_hash_zero = (in_hash == '0);
    sts.op_insert    = (op == CMD_INSERT);
    sts.div_busy     = div_busy;
    sts.slot_empty   = (hash_q == '0);
    sts.slot_match   = (hash_q == hash_r);
    sts.probe_last   = (n == cap_live - 1'b1);
    sts.clr_last     = (clr_ptr == ADDR_W'(TABLE_DEPTH - 1));
    sts.out_free     = !out_valid || out_ready;
  end

endmodule

### rtl/lpht_ctrl.sv
// lpht_ctrl: command sequencer for clear, insert and lookup
// depends on lpht_pkg
module lpht_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  lpht_pkg::sts_t sts,
  output lpht_pkg::ctl_t ctl
);
  import lpht_pkg::*;

  typedef enum logic [6:0] {
    ST_INIT      = 7'b0000001,
    ST_IDLE      = 7'b0000010,
    ST_CLEAR     = 7'b0000100,
    ST_DIVIDE    = 7'b0001000,
    ST_PROBE_RD  = 7'b0010000,
    ST_PROBE_CHK = 7'b0100000,
    ST_RESULT    = 7'b1000000
  } state_t;

  state_t    state;
  state_t    state_next;
  logic      res_found;
  logic      res_found_next;
  status_e_t res_status;
  status_e_t res_status_next;

  always_comb begin
    state_next      = state;
    res_found_next  = res_found;
    res_status_next = res_status;
    ctl             = '0;
    ctl.res_found   = res_found;
    ctl.res_status  = res_status;
    in_ready        = 1'b0;
    case (state)
      ST_INIT: begin
        // sweep after reset empties every slot
        ctl.clr_write = 1'b1;
        if (sts.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.accept      = 1'b1;
          res_found_next  = 1'b0;
          res_status_next = STATUS_OK;
          case (sts.in_cmd)
            CMD_CLEAR: begin
              ctl.clr_start = 1'b1;
              state_next    = ST_CLEAR;
            end
            CMD_INSERT, CMD_LOOKUP: begin
              if (sts.in_hash_zero) begin
                res_status_next = STATUS_ZERO;
                state_next      = ST_RESULT;
              end else begin
                ctl.div_start = 1'b1;
                state_next    = ST_DIVIDE;
              end
            end
            default: state_next = ST_RESULT;
          endcase
        end
      end
      ST_CLEAR: begin
        ctl.clr_write = 1'b1;
        if (sts.clr_last) state_next = ST_RESULT;
      end
      ST_DIVIDE: begin
        if (!sts.div_busy) begin
          ctl.probe_init = 1'b1;
          state_next     = ST_PROBE_RD;
        end
      end
      ST_PROBE_RD: begin
        state_next = ST_PROBE_CHK;
      end
      ST_PROBE_CHK: begin
        if (sts.op_insert && sts.slot_empty) begin
          ctl.ins_write = 1'b1;
          state_next    = ST_RESULT;
        end else if (!sts.op_insert && sts.slot_empty) begin
          res_status_next = STATUS_NOT_FOUND;
          state_next      = ST_RESULT;
        end else if (!sts.op_insert && sts.slot_match) begin
          res_found_next = 1'b1;
          state_next     = ST_RESULT;
        end else if (sts.probe_last) begin
          res_status_next = STATUS_FULL;
          state_next      = ST_RESULT;
        end else begin
          ctl.probe_advance = 1'b1;
          state_next        = ST_PROBE_RD;
        end
      end
      ST_RESULT: begin
        // wait here while the previous result is still held
        if (sts.out_free) begin
          ctl.load_result = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: state_next = ST_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      res_found  <= 1'b0;
      res_status <= STATUS_OK;
    end else begin
      state      <= state_next;
      res_found  <= res_found_next;
      res_status <= res_status_next;
    end
  end

endmodule

### rtl/linear_probe_hash_table.sv
// Open-addressing hash table with linear probing over TABLE_DEPTH slots of
// 64-bit hash and 64-bit offset; a zero hash marks an empty slot. After reset
// a clearing pass writes every slot, in which no item is taken (configuration
// writes still are). A clear command sweeps every slot the same way before
// its result is given. Insert and lookup first take the 64-bit remainder of
// the hash by the capacity, done 4 bits a cycle, then visit slots from that
// home slot; each probe is a read state, then a check state, as the read of
// the one memory port is registered. A zero hash or the unused command is
// answered without a division or a probe. One item is in work at a time; the
// result register lets the next item be taken while a result still waits.
// Depends on lpht_pkg, lpht_ctrl, lpht_datapath and lpht_rem.
module linear_probe_hash_table #(
  parameter int TABLE_DEPTH = lpht_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [lpht_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [lpht_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [lpht_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                               pready,
  // command stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [lpht_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // key_hash, entry_offset
  input  logic [lpht_pkg::IN_USER_W-1:0]     s_axis_tuser,  // cmd
  // result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [lpht_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // result_offset
  output logic [lpht_pkg::OUT_USER_W-1:0]    m_axis_tuser   // found, status
);
  import lpht_pkg::*;

  logic [CAP_CFG_W-1:0] capacity;
  logic                 cfg_wr;
  ctl_t                 ctl;
  sts_t                 sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready
                  && (paddr[CFG_ADDR_W-1:2] == REG_CAPACITY);

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_wr) begin
      capacity <= pwdata[CAP_CFG_W-1:0];
    end
  end

  assign prdata = (paddr[CFG_ADDR_W-1:2] == REG_CAPACITY) ?
                  CFG_DATA_W'(capacity) : '0;

  lpht_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .ctl      (ctl)
  );

  lpht_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .sts       (sts),
    .capacity  (capacity),
    .in_data   (s_axis_tdata),
    .in_user   (s_axis_tuser),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata),
    .out_user  (m_axis_tuser)
  );

endmodule

### test/testbench.sv
// testbench for linear_probe_hash_table: streams clear, insert, lookup and unused
// commands under several capacity settings and checks every result in order
// depends on lpht_pkg and the rtl under rtl/
module testbench;
  import lpht_pkg::*;

  localparam int SLOTS = DEFAULT_TABLE_DEPTH;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_REPORTS = 10;
  localparam int RUN_LENGTH = 50;
  localparam int RECENT_DEPTH = 48;

  typedef struct packed {
    cmd_e_t          cmd;
    logic [KEY_W-1:0] key_hash;
    logic [OFF_W-1:0] entry_offset;
  } table_cmd_t;

  typedef struct packed {
    logic             found;
    logic [OFF_W-1:0] offset;
    status_e_t        status;
  } table_reply_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // key_hash, entry_offset
  logic [IN_USER_W-1:0]  s_axis_tuser = '0;   // cmd
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;        // result_offset
  logic [OUT_USER_W-1:0] m_axis_tuser;        // found, status

  linear_probe_hash_table uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  always #2 clk = ~clk;

  // shadow copy of the table and its capacity register
  logic [KEY_W-1:0]     shadow_key [SLOTS];
  logic [OFF_W-1:0]     shadow_off [SLOTS];
  logic [CAP_CFG_W-1:0] shadow_capacity = CAP_RESET;

  table_cmd_t   cmd_backlog[$];
  table_reply_t pending_results[$];
  logic [KEY_W-1:0] recent_keys[$];

  logic        in_took = 1'b0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned items_queued = 0;
  int unsigned replies_seen = 0;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned settings_written = 0;
  int unsigned status_tally [4] = '{default: 0};

  initial begin
    foreach (shadow_key[i]) begin
      shadow_key[i] = '0;
      shadow_off[i] = '0;
    end
  end

  function automatic int unsigned probe_span(logic [CAP_CFG_W-1:0] setting);
    if (setting < MIN_CAPACITY) return MIN_CAPACITY;
    if (setting > SLOTS) return SLOTS;
    return setting;
  endfunction

  // applies one command to the shadow table and returns the answer it gives
  function automatic table_reply_t table_apply(cmd_e_t cmd, logic [KEY_W-1:0] h,
                                               logic [OFF_W-1:0] off);
    table_reply_t res;
    int unsigned span;
    int unsigned slot;
    res.found = 1'b0;
    res.offset = '0;
    res.status = STATUS_OK;
    if (cmd == CMD_CLEAR) begin
      foreach (shadow_key[i]) shadow_key[i] = '0;
      return res;
    end
    if (cmd != CMD_INSERT && cmd != CMD_LOOKUP) return res;
    if (h == '0) begin
      res.status = STATUS_ZERO;
      return res;
    end
    span = probe_span(shadow_capacity);
    slot = int'(h % KEY_W'(span));
    for (int n = 0; n < span; n++) begin
      if (cmd == CMD_INSERT && shadow_key[slot] == '0) begin
        shadow_key[slot] = h;
        shadow_off[slot] = off;
        return res;
      end
      if (cmd == CMD_LOOKUP) begin
        if (shadow_key[slot] == '0) begin
          res.status = STATUS_NOT_FOUND;
          return res;
        end
        if (shadow_key[slot] == h) begin
          res.found = 1'b1;
          res.offset = shadow_off[slot];
          return res;
        end
      end
      slot = (slot + 1 == span) ? 0 : slot + 1;
    end
    res.status = STATUS_FULL;
    return res;
  endfunction

  function automatic logic [63:0] random_word();
    return {$urandom, $urandom};
  endfunction

  // mostly hashes that pile up on the same home slots, some spread wide
  function automatic logic [KEY_W-1:0] pick_hash(int unsigned span);
    logic [KEY_W-1:0] h;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: h = KEY_W'($urandom_range(1, 4 * span));
      4, 5: h = random_word();
      6: h = '1 - KEY_W'($urandom_range(0, 255));
      7: h = {$urandom, 32'($urandom_range(1, 2 * span))};
      default: begin
        if (recent_keys.size() != 0)
          h = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
        else
          h = KEY_W'(span + 1);
      end
    endcase
    if (h == '0) h = KEY_W'(1);
    return h;
  endfunction

  task automatic queue_cmd(cmd_e_t cmd, logic [KEY_W-1:0] h, logic [OFF_W-1:0] off);
    table_cmd_t item;
    item.cmd = cmd;
    item.key_hash = h;
    item.entry_offset = off;
    cmd_backlog.push_back(item);
    items_queued++;
    if (cmd == CMD_INSERT && h != '0) begin
      recent_keys.push_back(h);
      if (recent_keys.size() > RECENT_DEPTH) void'(recent_keys.pop_front());
    end
  endtask

  task automatic settle();
    while (replies_seen != items_queued) @(negedge clk);
  endtask

  task automatic write_capacity(logic [CAP_CFG_W-1:0] value);
    logic [CFG_DATA_W-1:0] word;
    word = $urandom;
    word[CAP_CFG_W-1:0] = value;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_CAPACITY, 2'b00};
    pwdata <= word;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    shadow_capacity = value;
    settings_written++;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // overfill a small table, then probe for absent and present hashes
  task automatic fill_burst(int unsigned span);
    repeat (span + 2) queue_cmd(CMD_INSERT, pick_hash(span), random_word());
    repeat (3) queue_cmd(CMD_LOOKUP, random_word(), random_word());
    repeat (3) queue_cmd(CMD_LOOKUP, pick_hash(span), random_word());
  endtask

  task automatic random_run(int unsigned count, int unsigned span);
    int unsigned roll;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 2)
        queue_cmd(CMD_CLEAR, random_word(), random_word());
      else if (roll < 5)
        queue_cmd(CMD_NOP, random_word(), random_word());
      else if (roll < 8)
        queue_cmd(roll[0] ? CMD_INSERT : CMD_LOOKUP, '0, random_word());
      else if (roll < 52)
        queue_cmd(CMD_INSERT, pick_hash(span), random_word());
      else if (roll < 85 && recent_keys.size() != 0)
        queue_cmd(CMD_LOOKUP, recent_keys[$urandom_range(0, recent_keys.size() - 1)],
                  random_word());
      else
        queue_cmd(CMD_LOOKUP, pick_hash(span), random_word());
    end
  endtask

  // driver: next command goes out once the previous one was taken
  always @(negedge clk) begin
    table_cmd_t nxt;
    if (!rst && (!s_axis_tvalid || in_took)) begin
      if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        nxt = cmd_backlog.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {nxt.entry_offset, nxt.key_hash};
        s_axis_tuser <= nxt.cmd;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // monitor: check results, then predict for the command taken this edge
  always @(posedge clk) begin
    table_reply_t got;
    table_reply_t want;
    in_took <= !rst && s_axis_tvalid && s_axis_tready;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.found = m_axis_tuser[0];
        got.status = status_e_t'(m_axis_tuser[2:1]);
        got.offset = m_axis_tdata;
        replies_seen++;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("unexpected result: found=%0d offset=%h status=%0d",
                     got.found, got.offset, got.status);
        end else begin
          want = pending_results.pop_front();
          if (got.found !== want.found || got.offset !== want.offset ||
              got.status !== want.status) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("result %0d: expected found=%0d offset=%h status=%0d, got found=%0d offset=%h status=%0d",
                       replies_seen, want.found, want.offset, want.status,
                       got.found, got.offset, got.status);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = table_apply(cmd_e_t'(s_axis_tuser), s_axis_tdata[KEY_W-1:0],
                           s_axis_tdata[IN_DATA_W-1:KEY_W]);
        status_tally[want.status]++;
        pending_results.push_back(want);
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("no transfer for %0d cycles", idle_cycles);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    int unsigned tx_pct [3] = '{38, 77, 0};
    int unsigned rx_pct [3] = '{77, 38, 0};
    int unsigned cap_list [6] = '{16, 0, 2047, 17, 1024, 0};
    logic [CAP_CFG_W-1:0] setting;
    int unsigned span;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    tx_idle_pct = tx_pct[0];
    rx_idle_pct = rx_pct[0];
    write_capacity(CAP_RESET);

    // directed: empty table, zero hash, unused command, collisions,
    // duplicates, wraparound, extreme values, clear
    queue_cmd(CMD_LOOKUP, KEY_W'(5), '0);
    queue_cmd(CMD_INSERT, '0, random_word());
    queue_cmd(CMD_LOOKUP, '0, '0);
    queue_cmd(CMD_NOP, '1, '1);
    queue_cmd(CMD_INSERT, KEY_W'(5), '0);
    queue_cmd(CMD_INSERT, KEY_W'(21), random_word());
    queue_cmd(CMD_INSERT, KEY_W'(5), '1);
    queue_cmd(CMD_LOOKUP, KEY_W'(21), '0);
    queue_cmd(CMD_LOOKUP, KEY_W'(5), '0);
    queue_cmd(CMD_LOOKUP, KEY_W'(37), '0);
    queue_cmd(CMD_INSERT, '1, '1);
    queue_cmd(CMD_INSERT, KEY_W'(31), random_word());
    queue_cmd(CMD_LOOKUP, '1, '0);
    queue_cmd(CMD_LOOKUP, KEY_W'(31), '0);
    queue_cmd(CMD_CLEAR, '1, '1);
    queue_cmd(CMD_LOOKUP, KEY_W'(5), '0);
    queue_cmd(CMD_LOOKUP, KEY_W'(31), '0);
    settle();

    for (int mode = 0; mode < 3; mode++) begin
      tx_idle_pct = tx_pct[mode];
      rx_idle_pct = rx_pct[mode];
      for (int k = 0; k < 6; k++) begin
        setting = (k == 5) ? CAP_CFG_W'($urandom_range(0, 2047)) : CAP_CFG_W'(cap_list[k]);
        // slots are kept across the change unless a clear comes along
        write_capacity(setting);
        span = probe_span(setting);
        if (span <= 40) fill_burst(span);
        random_run(RUN_LENGTH, span);
        settle();
      end
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0d expected results never arrived", pending_results.size());
      mismatches += pending_results.size();
    end
    $display("%0d commands over %0d capacity writes, %0d results compared, %0d mismatches",
             items_queued, settings_written, replies_seen, mismatches);
    $display("answers: ok %0d, not found %0d, table full %0d, zero hash %0d",
             status_tally[STATUS_OK], status_tally[STATUS_NOT_FOUND],
             status_tally[STATUS_FULL], status_tally[STATUS_ZERO]);
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

### files.f
rtl/lpht_pkg.sv
rtl/lpht_rem.sv
rtl/lpht_datapath.sv
rtl/lpht_ctrl.sv
rtl/linear_probe_hash_table.sv
test/testbench.sv
